/* sv/psda_pkg.sv */
`default_nettype none
package psda_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int TIME_BITS_DEF  = 32;
   localparam int CORDIC_STEPS   = 20;
   localparam int LEN_W          = 21;
   localparam int ANG_W          = 15;
   localparam int DELTA_W        = 17;
   localparam int OUT_W          = 32;
   localparam int RSP_W          = 176;
   localparam int ANGLE_LIMIT    = 11520;
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_NEG  = 2'd1;
   localparam logic [1:0] DIR_POS  = 2'd2;

   // atan(2^-i) in degrees, Q.16.
   function automatic logic [21:0] atan_q16(input logic [4:0] i);
      logic [21:0] v;
      case (i)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         default: v = 22'd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

/* sv/psda_front.sv */
`default_nettype none
// Takes samples, forms deltas and elapsed time against the previous sample.
module psda_front import psda_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [TIME_BITS-1:0]         in_time,
   input  wire logic signed [COORD_BITS-1:0] in_x,
   input  wire logic signed [COORD_BITS-1:0] in_y,
   output logic                              q_valid,
   input  wire logic                         q_ready,
   output logic                              q_seg,
   output logic signed [COORD_BITS:0]        q_dx,
   output logic signed [COORD_BITS:0]        q_dy,
   output logic [TIME_BITS-1:0]              q_et
);
   logic have_ff, have_in;
   logic [TIME_BITS-1:0] pt_ff, pt_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic fire;

   assign in_ready = q_ready;
   assign q_valid  = in_valid;
   assign fire     = in_valid && q_ready;
   assign q_seg    = have_ff;
   assign q_dx     = {in_x[COORD_BITS-1], in_x} - {px_ff[COORD_BITS-1], px_ff};
   assign q_dy     = {in_y[COORD_BITS-1], in_y} - {py_ff[COORD_BITS-1], py_ff};
   assign q_et     = in_time - pt_ff;

   always_comb begin
      have_in = have_ff;
      pt_in = pt_ff;
      px_in = px_ff;
      py_in = py_ff;
      if (fire) begin
         have_in = 1'b1;
         pt_in = in_time;
         px_in = in_x;
         py_in = in_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         pt_ff <= '0;
         px_ff <= '0;
         py_ff <= '0;
      end else begin
         have_ff <= have_in;
         pt_ff <= pt_in;
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end
endmodule
`default_nettype wire

/* sv/psda_queue.sv */
`default_nettype none
// Two-entry queue between the front and back parts.
module psda_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic [WIDTH-1:0] mem0_in, mem1_in;
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      mem0_in = mem_ff[0];
      mem1_in = mem_ff[1];
      if (push && !wp_ff) mem0_in = in_data;
      if (push && wp_ff) mem1_in = in_data;
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      mem_ff[0] <= mem0_in;
      mem_ff[1] <= mem1_in;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

/* sv/psda_back.sv */
`default_nettype none
// Sequencer: multiply, root two bits a step, CORDIC one step a cycle,
// restoring divide one bit a cycle, then dwell bookkeeping and the result.
module psda_back import psda_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_valid,
   output logic                              q_ready,
   input  wire logic                         q_seg,
   input  wire logic signed [COORD_BITS:0]   q_dx,
   input  wire logic signed [COORD_BITS:0]   q_dy,
   input  wire logic [TIME_BITS-1:0]         q_et,
   output logic                              o_valid,
   input  wire logic                         o_ready,
   output logic [RSP_W-1:0]                  o_data
);
   localparam int SQ_W  = 2*COORD_BITS + 10;            // (dx^2+dy^2)<<8
   localparam int RT_W  = SQ_W/2 + 1;
   localparam int SQ_IT = (SQ_W+1)/2;
   localparam int CW    = COORD_BITS + 16;              // cordic x/y
   localparam int NUM_W = RT_W + 12;
   localparam int DIV_W = NUM_W;
   localparam int CNT_W = $clog2(DIV_W + SQ_IT + CORDIC_STEPS + 2);

   localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_SQRT = 3'd2, S_CORD = 3'd3,
                          S_DIV = 3'd4, S_OUT = 3'd5;

   logic [2:0] st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic seg_ff, seg_in;
   logic signed [COORD_BITS:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [TIME_BITS-1:0] et_ff, et_in;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0] rt_ff, rt_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0] z_ff, z_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [TIME_BITS:0] drem_ff, drem_in;
   logic run_ff, run_in;
   logic [OUT_W-1:0] tot_ff, tot_in;
   logic [RSP_W-1:0] od_ff, od_in;
   logic ov_ff, ov_in;
   logic [2*COORD_BITS+1:0] mx_ff, mx_in, my_ff, my_in;

   logic signed [CW-1:0] xs, ys;
   logic [TIME_BITS:0] dtry;
   logic moving;
   logic signed [COORD_BITS:0] ax, ay;
   logic signed [25:0] zr;
   logic signed [ANG_W-1:0] ang;
   logic [LEN_W-1:0] len;
   logic [OUT_W-1:0] spd, dwt, etw;
   logic dwv;
   logic [OUT_W:0] ssum;
   logic [SQ_W-1:0] rbit;

   assign q_ready = (st_ff == S_IDLE);
   assign o_valid = ov_ff;
   assign o_data  = od_ff;
   assign moving  = (dx_ff != 0) || (dy_ff != 0);
   assign xs = cx_ff >>> cnt_ff[4:0];
   assign ys = cy_ff >>> cnt_ff[4:0];

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; seg_in = seg_ff; dx_in = dx_ff; dy_in = dy_ff;
      et_in = et_ff; rem_in = rem_ff; rt_in = rt_ff; cx_in = cx_ff;
      cy_in = cy_ff; z_in = z_ff; num_in = num_ff; drem_in = drem_ff; run_in = run_ff;
      tot_in = tot_ff; od_in = od_ff; ov_in = ov_ff; mx_in = mx_ff; my_in = my_ff;
      ax = '0; ay = '0; dtry = '0; zr = '0; ang = '0; len = '0; spd = '0;
      dwt = '0; dwv = 1'b0; ssum = '0; etw = '0; rbit = '0;
      if (ov_ff && o_ready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               seg_in = q_seg; dx_in = q_dx; dy_in = q_dy; et_in = q_et;
               st_in = q_seg ? S_MUL : S_OUT;
            end
         end
         S_MUL: begin
            mx_in = (2*COORD_BITS+2)'(dx_ff * dx_ff);
            my_in = (2*COORD_BITS+2)'(dy_ff * dy_ff);
            st_in = S_SQRT; cnt_in = '0;
            if (cnt_ff == '0) st_in = S_MUL;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               rem_in = SQ_W'({mx_ff + my_ff, 8'd0});
               rt_in = '0; cnt_in = '0; st_in = S_SQRT;
            end
         end
         S_SQRT: begin
            rbit = SQ_W'(1) << (2*(SQ_IT-1) - 2*int'(cnt_ff));
            // classic digit-by-digit root
            if ({2'b0, rem_ff} >=
                {2'b0, (SQ_W'(rt_ff) << (2*(SQ_IT-int'(cnt_ff)))) | rbit}) begin
               rem_in = rem_ff - ((SQ_W'(rt_ff) << (2*(SQ_IT-int'(cnt_ff)))) | rbit);
               rt_in = {rt_ff[RT_W-2:0], 1'b1};
            end else begin
               rt_in = {rt_ff[RT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) == SQ_IT-1) begin
               cnt_in = '0; st_in = S_CORD;
               ax = -dx_ff; ay = -dy_ff;
               if (ax < 0) begin
                  cx_in = CW'(-ax) <<< 12; cy_in = CW'(-ay) <<< 12;
                  z_in = (ay >= 0) ? 26'sd11796480 : -26'sd11796480;
               end else begin
                  cx_in = CW'(ax) <<< 12; cy_in = CW'(ay) <<< 12; z_in = '0;
               end
            end
         end
         S_CORD: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + ys; cy_in = cy_ff - xs;
               z_in = z_ff + $signed({4'b0, atan_q16(cnt_ff[4:0])});
            end else begin
               cx_in = cx_ff - ys; cy_in = cy_ff + xs;
               z_in = z_ff - $signed({4'b0, atan_q16(cnt_ff[4:0])});
            end
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) == CORDIC_STEPS-1) begin
               cnt_in = '0; st_in = S_DIV;
               num_in = NUM_W'({rt_ff, 12'd0}); drem_in = '0;
            end
         end
         S_DIV: begin
            dtry = {drem_ff[TIME_BITS-1:0], num_ff[NUM_W-1]};
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            if (dtry >= {1'b0, et_ff} && et_ff != '0) begin
               drem_in = dtry - {1'b0, et_ff}; num_in[0] = 1'b1;
            end else begin
               drem_in = dtry;
            end
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) == DIV_W-1) st_in = S_OUT;
         end
         default: begin
            if (!ov_ff || o_ready) begin
               etw = OUT_W'(et_ff);
               if (seg_ff) begin
                  len = LEN_W'(rt_ff);
                  zr = (z_ff + 26'sd512) >>> 10;
                  if (zr > ANGLE_LIMIT) ang = ANG_W'(ANGLE_LIMIT);
                  else if (zr < -ANGLE_LIMIT) ang = -ANG_W'(ANGLE_LIMIT);
                  else ang = ANG_W'(zr);
                  if (!moving) ang = '0;
                  if (et_ff == '0 || (NUM_W > OUT_W && |(num_ff >> OUT_W)))
                     spd = '1;
                  else spd = OUT_W'(num_ff);
                  if (!moving) begin
                     ssum = {1'b0, tot_ff} + {1'b0, etw};
                     tot_in = ssum[OUT_W] ? '1 : ssum[OUT_W-1:0];
                     run_in = 1'b1;
                  end else if (run_ff) begin
                     dwv = 1'b1; dwt = tot_ff; run_in = 1'b0; tot_in = '0;
                  end
                  od_in = RSP_W'({dwt, dwv,
                     (dy_ff < 0) ? DIR_NEG : (dy_ff > 0) ? DIR_POS : DIR_NONE,
                     (dx_ff < 0) ? DIR_NEG : (dx_ff > 0) ? DIR_POS : DIR_NONE,
                     moving, spd, ang, len, etw,
                     DELTA_W'(dy_ff), DELTA_W'(dx_ff), 1'b1});
               end else begin
                  od_in = '0;
               end
               ov_in = 1'b1; st_in = S_IDLE; cnt_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in; dy_ff <= dy_in; et_ff <= et_in; rem_ff <= rem_in;
      rt_ff <= rt_in; cx_ff <= cx_in; cy_ff <= cy_in; z_ff <= z_in; num_ff <= num_in;
      drem_ff <= drem_in; od_ff <= od_in; mx_ff <= mx_in; my_ff <= my_in; seg_ff <= seg_in;
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; run_ff <= 1'b0; tot_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; run_ff <= run_in; tot_ff <= tot_in; ov_ff <= ov_in;
      end
   end
endmodule
`default_nettype wire

/* sv/pointer_segment_dwell_analyzer.sv */
// A word with a segment passes through the back-end sequencer's multiply, square root,
// CORDIC, divide and output states in turn; the first sample after reset has no segment
// and goes from idle straight to output. The sequencer takes one word at a time (root,
// CORDIC and divider run one after another); a stalled output holds it longer.
// A two-entry queue lets the front take words while the back end is busy.
// Reset is synchronous and active high; it forgets the previous sample and dwell.
`default_nettype none
module pointer_segment_dwell_analyzer import psda_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // sample_time, pos_x, pos_y from the lowest bit up
   input  wire logic [((TIME_BITS+2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // seg_valid, delta_x, delta_y, seg_time, seg_length, seg_angle, seg_speed,
   // is_moving, dir_x, dir_y, dwell_valid, dwell_time, from the lowest bit up
   output logic [RSP_W-1:0]                     rsp_tdata
);
   localparam int QW = 1 + 2*(COORD_BITS+1) + TIME_BITS;

   logic f_valid, f_ready, f_seg, b_valid, b_ready;
   logic signed [COORD_BITS:0] f_dx, f_dy;
   logic [TIME_BITS-1:0] f_et;
   logic [QW-1:0] qin, qout;

   psda_front #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_time(req_tdata[TIME_BITS-1:0]),
      .in_x(req_tdata[TIME_BITS+COORD_BITS-1:TIME_BITS]),
      .in_y(req_tdata[TIME_BITS+2*COORD_BITS-1:TIME_BITS+COORD_BITS]),
      .q_valid(f_valid), .q_ready(f_ready), .q_seg(f_seg), .q_dx(f_dx), .q_dy(f_dy),
      .q_et(f_et));

   assign qin = {f_seg, f_dx, f_dy, f_et};

   psda_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(qin),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(qout));

   psda_back #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_back (
      .clock, .reset, .q_valid(b_valid), .q_ready(b_ready),
      .q_seg(qout[QW-1]),
      .q_dx(qout[QW-2:QW-2-COORD_BITS]),
      .q_dy(qout[QW-3-COORD_BITS:TIME_BITS]),
      .q_et(qout[TIME_BITS-1:0]),
      .o_valid(rsp_tvalid), .o_ready(rsp_tready), .o_data(rsp_tdata));
endmodule
`default_nettype wire
